[rtl/irt_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irt_pkg
// Shared types and constants for the interval range table.
// ----------------------------------------------------------------------------
package irt_pkg;

  typedef enum logic {
    OP_ASSIGN = 1'b0,
    OP_LOOKUP = 1'b1
  } op_t;

  typedef enum logic {
    ST_DONE    = 1'b0,
    ST_REFUSED = 1'b1
  } status_t;

  localparam int COUNT_WIDTH = 5;

endpackage

[rtl/interval_range_table.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interval_range_table
// Sorted boundary table mapping signed keys to values, with range assign
// and key lookup, driven by a small sequencer around one shared comparator.
// ----------------------------------------------------------------------------
// Channel   Signals                                        Direction
// in        in_valid, in_stall, operation .. lookup_key    item into block
// out       out_valid, out_stall, read_value .. count      result out
// cfg       cfg_write, cfg_data                            default value
//
// A lookup reads the stored boundaries one at a time until the first one past
// its key; an applied assign reads every stored boundary. Both are paced by
// the single read port of the boundary memory and the one comparator.
// The table is rebuilt into the other half of a two-bank memory and the bank
// is swapped at the end. Reset clears the count, so no clearing pass runs.
// A stalled result holds the sequencer until it is taken.
// ----------------------------------------------------------------------------
module interval_range_table #(
  parameter int CAPACITY    = 16,
  parameter int KEY_WIDTH   = 32,
  parameter int VALUE_WIDTH = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [VALUE_WIDTH-1:0]        cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          operation,
  input  logic signed [KEY_WIDTH-1:0]   range_begin,
  input  logic signed [KEY_WIDTH-1:0]   range_end,
  input  logic [VALUE_WIDTH-1:0]        new_value,
  input  logic signed [KEY_WIDTH-1:0]   lookup_key,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [VALUE_WIDTH-1:0]        read_value,
  output logic                          status,
  output logic [irt_pkg::COUNT_WIDTH-1:0] entry_count
);
  import irt_pkg::*;

  localparam int IW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int AW  = IW + 1;
  localparam int CNW = $clog2(CAPACITY + 1);
  localparam int KW  = $clog2(CAPACITY + 3);
  localparam logic [KEY_WIDTH-1:0] SIGN = {1'b1, {(KEY_WIDTH-1){1'b0}}};

  typedef enum logic [2:0] {
    S_IDLE, S_CHK, S_RD, S_WT, S_EMIT_B, S_EMIT_E, S_FIN
  } state_t;

  typedef enum logic [1:0] {
    PH_LOOK, PH_PRE, PH_MID, PH_POST
  } phase_t;

  state_t state;
  phase_t phase;
  op_t    op;
  logic   bank;
  logic   applied;
  logic [CNW-1:0] cnt;
  logic [CNW-1:0] idx;
  logic [KW-1:0]  kept;
  logic [KEY_WIDTH-1:0]   bk;
  logic [KEY_WIDTH-1:0]   ek;
  logic [VALUE_WIDTH-1:0] nv;
  logic [VALUE_WIDTH-1:0] cur;
  logic [VALUE_WIDTH-1:0] prev;
  logic [VALUE_WIDTH-1:0] default_value;

  logic [KEY_WIDTH-1:0]   mem_k [2**AW];
  logic [VALUE_WIDTH-1:0] mem_v [2**AW];
  logic [KEY_WIDTH-1:0]   rkey;
  logic [VALUE_WIDTH-1:0] rval;

  logic                   rd_en;
  logic                   emit_en;
  logic [KEY_WIDTH-1:0]   emit_key;
  logic [VALUE_WIDTH-1:0] emit_val;
  logic                   wr_en;
  logic [KEY_WIDTH-1:0]   cmp_a;
  logic [KEY_WIDTH-1:0]   cmp_ref;
  logic                   cmp_lt;
  logic                   cmp_eq;
  logic                   at_end;

  assign in_stall = (state != S_IDLE);
  assign at_end   = (idx == cnt);

  always_comb begin
    if (state == S_CHK) begin
      cmp_a   = bk;
      cmp_ref = ek;
    end else begin
      cmp_a   = rkey;
      cmp_ref = (phase == PH_PRE) ? bk : ek;
    end
  end

  assign cmp_lt = (cmp_a < cmp_ref);
  assign cmp_eq = (cmp_a == cmp_ref);

  always_comb begin
    emit_en  = 1'b0;
    emit_key = rkey;
    emit_val = rval;
    unique case (state)
      S_WT: begin
        emit_en = (phase == PH_POST) || ((phase == PH_PRE) && cmp_lt);
      end
      S_EMIT_B: begin
        emit_en  = 1'b1;
        emit_key = bk;
        emit_val = nv;
      end
      S_EMIT_E: begin
        emit_en  = 1'b1;
        emit_key = ek;
        emit_val = cur;
      end
      default: begin
        emit_en = 1'b0;
      end
    endcase
  end

  assign wr_en = emit_en && (emit_val != prev) && (kept < KW'(CAPACITY));
  assign rd_en = (state == S_RD) && !at_end;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_k[{~bank, kept[IW-1:0]}] <= emit_key;
      mem_v[{~bank, kept[IW-1:0]}] <= emit_val;
    end
    if (rd_en) begin
      rkey <= mem_k[{bank, idx[IW-1:0]}];
      rval <= mem_v[{bank, idx[IW-1:0]}];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      phase         <= PH_LOOK;
      bank          <= 1'b0;
      cnt           <= '0;
      out_valid     <= 1'b0;
      default_value <= '0;
    end else begin
      if (cfg_write) begin
        default_value <= cfg_data;
      end
      if (out_valid && !out_stall && (state != S_FIN)) begin
        out_valid <= 1'b0;
      end
      if (emit_en && (emit_val != prev)) begin
        kept <= kept + 1'b1;
        prev <= emit_val;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            op      <= op_t'(operation);
            bk      <= range_begin ^ SIGN;
            ek      <= (operation == OP_LOOKUP) ? (lookup_key ^ SIGN) : (range_end ^ SIGN);
            nv      <= new_value;
            cur     <= default_value;
            prev    <= default_value;
            kept    <= '0;
            idx     <= '0;
            applied <= 1'b0;
            if (operation == OP_LOOKUP) begin
              phase <= PH_LOOK;
              state <= S_RD;
            end else begin
              phase <= PH_PRE;
              state <= S_CHK;
            end
          end
        end
        S_CHK: begin
          applied <= cmp_lt;
          state   <= cmp_lt ? S_RD : S_FIN;
        end
        S_RD: begin
          if (!at_end) begin
            state <= S_WT;
          end else if (phase == PH_PRE || phase == PH_MID) begin
            state <= S_EMIT_B;
          end else begin
            state <= S_FIN;
          end
        end
        S_WT: begin
          unique case (phase)
            PH_LOOK: begin
              if (!cmp_lt && !cmp_eq) begin
                state <= S_FIN;
              end else begin
                cur   <= rval;
                idx   <= idx + 1'b1;
                state <= S_RD;
              end
            end
            PH_PRE: begin
              if (cmp_lt) begin
                cur   <= rval;
                idx   <= idx + 1'b1;
                state <= S_RD;
              end else begin
                phase <= PH_MID;
              end
            end
            PH_MID: begin
              if (cmp_lt || cmp_eq) begin
                cur   <= rval;
                idx   <= idx + 1'b1;
                state <= S_RD;
              end else begin
                state <= S_EMIT_B;
              end
            end
            PH_POST: begin
              idx   <= idx + 1'b1;
              state <= S_RD;
            end
          endcase
        end
        S_EMIT_B: begin
          state <= S_EMIT_E;
        end
        S_EMIT_E: begin
          phase <= PH_POST;
          state <= at_end ? S_FIN : S_WT;
        end
        S_FIN: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
            if (op == OP_LOOKUP) begin
              read_value  <= cur;
              status      <= ST_DONE;
              entry_count <= COUNT_WIDTH'(cnt);
            end else if (applied && (kept > KW'(CAPACITY))) begin
              read_value  <= '0;
              status      <= ST_REFUSED;
              entry_count <= COUNT_WIDTH'(cnt);
            end else if (applied) begin
              read_value  <= '0;
              status      <= ST_DONE;
              entry_count <= COUNT_WIDTH'(kept);
              cnt         <= CNW'(kept);
              bank        <= ~bank;
            end else begin
              read_value  <= '0;
              status      <= ST_DONE;
              entry_count <= COUNT_WIDTH'(cnt);
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the interval range table. A behavioural copy of the
// table predicts the result of every accepted item and a small scoreboard
// compares each result as a whole, under random gaps and stalls.
// ----------------------------------------------------------------------------
module tb;
  import irt_pkg::*;

  localparam int CAP = 16;
  localparam longint CYCLE_LIMIT = 1500000;

  typedef struct packed {
    logic [7:0] read_value;
    logic       status;
    logic [4:0] entry_count;
  } table_result_t;

  class table_scoreboard;
    table_result_t pending[$];
    int errors;

    function void note_item(table_result_t r);
      pending.push_back(r);
    endfunction

    function void check_result(table_result_t got);
      table_result_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("ERROR: unexpected result %p", got);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10) $display("ERROR: expected %p, got %p", want, got);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic cfg_write = 0;
  logic [7:0] cfg_data = '0;
  logic in_valid = 0;
  logic in_stall;
  logic operation = 0;
  logic signed [31:0] range_begin = '0, range_end = '0, lookup_key = '0;
  logic [7:0] new_value = '0;
  logic out_valid;
  logic out_stall = 0;
  logic [7:0] read_value;
  logic status;
  logic [4:0] entry_count;

  interval_range_table uut (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .operation(operation),
    .range_begin(range_begin), .range_end(range_end), .new_value(new_value),
    .lookup_key(lookup_key), .out_valid(out_valid), .out_stall(out_stall),
    .read_value(read_value), .status(status), .entry_count(entry_count)
  );

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  table_scoreboard board = new();
  logic [31:0] bkeys[CAP];
  logic [7:0] bvals[CAP];
  int bcount;
  logic [7:0] dflt;
  longint cycles = 0;
  bit hold_off;
  int keypool[8];

  function automatic logic [7:0] value_for(logic [31:0] k);
    logic [7:0] v;
    v = dflt;
    for (int i = 0; i < bcount; i++) begin
      if (bkeys[i] <= k) v = bvals[i];
      else break;
    end
    return v;
  endfunction

  function automatic table_result_t predict_table(op_t op, logic [31:0] b_in,
      logic [31:0] e_in, logic [7:0] v, logic [31:0] lk);
    table_result_t r;
    logic [31:0] b, e, tk[CAP+2];
    logic [7:0] tv[CAP+2], prev, ev;
    int n, kept;
    r = '0;
    if (op == OP_LOOKUP) begin
      r.read_value = value_for(lk ^ 32'h8000_0000);
    end else begin
      b = b_in ^ 32'h8000_0000;
      e = e_in ^ 32'h8000_0000;
      if (b < e) begin
        ev = value_for(e);
        n = 0;
        for (int i = 0; i < bcount; i++)
          if (bkeys[i] < b) begin tk[n] = bkeys[i]; tv[n] = bvals[i]; n++; end
        tk[n] = b; tv[n] = v; n++;
        tk[n] = e; tv[n] = ev; n++;
        for (int i = 0; i < bcount; i++)
          if (bkeys[i] > e) begin tk[n] = bkeys[i]; tv[n] = bvals[i]; n++; end
        prev = dflt;
        kept = 0;
        for (int i = 0; i < n; i++)
          if (tv[i] != prev) begin
            tk[kept] = tk[i]; tv[kept] = tv[i]; kept++; prev = tv[i];
          end
        if (kept > CAP) begin
          r.status = ST_REFUSED;
        end else begin
          for (int i = 0; i < kept; i++) begin bkeys[i] = tk[i]; bvals[i] = tv[i]; end
          bcount = kept;
        end
      end
    end
    r.entry_count = bcount[4:0];
    return r;
  endfunction

  function automatic int pick_key();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom();
      default: return keypool[$urandom_range(0, 7)] + $urandom_range(0, 3) - 1;
    endcase
  endfunction

  task automatic gap(int hi_chance);
    int n;
    n = ($urandom_range(0, 99) < hi_chance) ? $urandom_range(20, 80) : $urandom_range(0, 2);
    if ($urandom_range(0, 2) == 0) n = 0;
    repeat (n) @(posedge clk);
  endtask

  task automatic send_item(op_t op, logic [31:0] b, logic [31:0] e, logic [7:0] v,
      logic [31:0] lk);
    in_valid <= 1;
    operation <= op;
    range_begin <= b;
    range_end <= e;
    new_value <= v;
    lookup_key <= lk;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_item(predict_table(op, b, e, v, lk));
    in_valid <= 0;
    @(posedge clk);
  endtask

  task automatic assign_range(logic [31:0] b, logic [31:0] e, logic [7:0] v);
    send_item(OP_ASSIGN, b, e, v, $urandom());
  endtask

  task automatic lookup(logic [31:0] k);
    send_item(OP_LOOKUP, $urandom(), $urandom(), 8'($urandom()), k);
  endtask

  task automatic write_default(logic [7:0] d);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    cfg_write <= 1;
    cfg_data <= d;
    @(posedge clk);
    cfg_write <= 0;
    dflt = d;
  endtask

  task automatic random_phase(int items);
    for (int i = 0; i < 8; i++) keypool[i] = $urandom_range(0, 60) * 4 - 120;
    for (int i = 0; i < items; i++) begin
      int a, c;
      gap(3);
      if ($urandom_range(0, 2) == 0) begin
        lookup(pick_key());
      end else begin
        a = pick_key();
        c = ($urandom_range(0, 9) == 0) ? pick_key() : a + $urandom_range(1, 40);
        if ($signed(c) < $signed(a) && $urandom_range(0, 1)) c = 32'h7fff_ffff;
        assign_range(a, c, $urandom_range(0, 5) == 0 ? 8'($urandom())
                                                     : 8'($urandom_range(0, 3)));
      end
    end
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      board.check_result(table_result_t'{read_value, status, entry_count});
  end

  initial begin
    int n;
    bit held;
    held = 0;
    forever begin
      @(posedge clk);
      if (hold_off && !held) begin
        out_stall <= 1;
        repeat (400) @(posedge clk);
        out_stall <= 0;
        held = 1;
      end else if ($urandom_range(0, 3) == 0) begin
        n = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 90) : $urandom_range(1, 3);
        out_stall <= 1;
        repeat (n) @(posedge clk);
        out_stall <= 0;
      end else if ($urandom_range(0, 7) == 0) begin
        repeat ($urandom_range(20, 60)) @(posedge clk);
      end
    end
  end

  initial begin
    dflt = 0;
    bcount = 0;
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    lookup(32'h8000_0000);
    lookup(32'h7fff_ffff);
    assign_range(5, 5, 8'hff);
    assign_range(9, 2, 8'h11);
    assign_range(32'h8000_0000, 32'h7fff_ffff, 8'hff);
    lookup(32'h8000_0000);
    lookup(32'h7fff_fffe);
    lookup(32'h7fff_ffff);
    assign_range(32'h8000_0000, 32'h7fff_ffff, 8'h00);
    assign_range(-10, 10, 8'h00);
    assign_range(-10, 10, 8'h5a);
    assign_range(0, 4, 8'h5a);
    assign_range(-20, -10, 8'h5a);
    lookup(-11);
    lookup(10);
    for (int i = 0; i < 18; i++) assign_range(100 + 4 * i, 102 + 4 * i, 8'(i + 1));
    lookup(101);
    lookup(32'hffff_ffff);
    write_default(8'h01);
    assign_range(0, 1, 8'h01);
    lookup(-5);

    hold_off = 1;
    for (int i = 0; i < 20; i++) lookup($urandom_range(0, 200));

    write_default(8'hff);
    random_phase(650);
    write_default(8'h00);
    random_phase(650);
    write_default(8'($urandom()));
    random_phase(600);

    while (board.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (board.errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end
endmodule

[sim.f]
rtl/irt_pkg.sv
rtl/interval_range_table.sv
verif/tb.sv
